>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file cbd_checker.sv.
// Each expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define CBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define CBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cbd_pkg.sv
// Package for the console bus decoder: codes, field widths, bus map, result beat.
// No dependencies.
package cbd_pkg;

  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int SRATE_W      = 18;
  localparam int CRATE_W      = 21;
  localparam int RAM_DEPTH_DEF = 2048;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_CART = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_PPU  = 3'd3,
    TGT_APU  = 3'd4,
    TGT_PAD  = 3'd5,
    TGT_DMA  = 3'd6
  } target_t;

  typedef enum logic [1:0] {
    DMA_NONE   = 2'd0,
    DMA_RD_REQ = 2'd1,
    DMA_WR_OAM = 2'd2
  } dma_op_t;

  typedef enum logic {
    CFG_SAMPLE_RATE    = 1'b0,
    CFG_CPU_CLOCK_RATE = 1'b1
  } cfg_idx_t;

  localparam logic [ADDR_W-1:0] RAM_END      = 16'h2000;
  localparam logic [ADDR_W-1:0] PPU_END      = 16'h4000;
  localparam logic [ADDR_W-1:0] APU_BASE     = 16'h4000;
  localparam logic [ADDR_W-1:0] APU_LAST     = 16'h4013;
  localparam logic [ADDR_W-1:0] APU_STATUS   = 16'h4015;
  localparam logic [ADDR_W-1:0] APU_FRAME    = 16'h4017;
  localparam logic [ADDR_W-1:0] OAM_DMA_ADDR = 16'h4014;
  localparam logic [ADDR_W-1:0] PAD_ADDR     = 16'h4016;

  localparam logic [SRATE_W-1:0] SAMPLE_RATE_RST    = 18'd44100;
  localparam logic [CRATE_W-1:0] CPU_CLOCK_RATE_RST = 21'd1789773;

  localparam logic [2:0] PHASE_EVEN = 3'd0;
  localparam logic [2:0] PHASE_ODD  = 3'd3;
  localparam logic [2:0] PHASE_LAST = 3'd5;

  typedef struct packed {
    target_t             target;
    logic [ADDR_W-1:0]   local_address;
    logic [DATA_W-1:0]   read_data;
    logic                cpu_step;
    logic                apu_step;
    dma_op_t             dma_op;
    logic [ADDR_W-1:0]   dma_address;
    logic [DATA_W-1:0]   dma_data;
    logic                sample_pulse;
    logic                cpu_nmi;
    logic                cpu_irq;
  } res_t;

endpackage

>>> rtl/core/cbd_in_if.sv
// Input channel: one bus access or master tick per beat.
// Depends on cbd_pkg.
interface cbd_in_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic              cart_claims;
  logic [DATA_W-1:0] pad_buttons;
  logic [DATA_W-1:0] bus_read_data;
  logic              ppu_nmi;
  logic              apu_irq;

  modport source (
    output valid, kind, address, write_data, cart_claims, pad_buttons,
           bus_read_data, ppu_nmi, apu_irq,
    input  ready
  );
  modport sink (
    input  valid, kind, address, write_data, cart_claims, pad_buttons,
           bus_read_data, ppu_nmi, apu_irq,
    output ready
  );
endinterface

>>> rtl/core/cbd_out_if.sv
// Result channel: one decode result per beat.
// Depends on cbd_pkg.
interface cbd_out_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        target;
  logic [ADDR_W-1:0] local_address;
  logic [DATA_W-1:0] read_data;
  logic              cpu_step;
  logic              apu_step;
  logic [1:0]        dma_op;
  logic [ADDR_W-1:0] dma_address;
  logic [DATA_W-1:0] dma_data;
  logic              sample_pulse;
  logic              cpu_nmi;
  logic              cpu_irq;

  modport source (
    output valid, target, local_address, read_data, cpu_step, apu_step, dma_op,
           dma_address, dma_data, sample_pulse, cpu_nmi, cpu_irq,
    input  ready
  );
  modport sink (
    input  valid, target, local_address, read_data, cpu_step, apu_step, dma_op,
           dma_address, dma_data, sample_pulse, cpu_nmi, cpu_irq,
    output ready
  );
endinterface

>>> rtl/core/cbd_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on cbd_pkg.
interface cbd_cfg_if;
  import cbd_pkg::*;

  logic               valid;
  logic               ready;
  logic               index;
  logic [CRATE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/cbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/core/cpu_bus_decoder_with_oam_dma.sv
// Top level of the console bus decoder with OAM DMA and work RAM.
// Depends on cbd_pkg, cbd_in_if, cbd_out_if, cbd_cfg_if and cbd_ram.
//
//   channel  | dir | handshake   | beat
//   in_if    | in  | valid/ready | tick or CPU access
//   out_if   | out | valid/ready | decode result
//   cfg_if   | in  | valid/ready | register write (index, data)
//
// One beat accepted per cycle while in_if.ready is high; its result passes
// through the stage-1 register (RAM read) and the output register.
// After reset all RAM_DEPTH words (2048 by default) are cleared;
// in_if.ready stays low meanwhile, cfg writes are taken at any time.
// A stalled output holds one result and one more beat may enter behind it.
module cpu_bus_decoder_with_oam_dma #(
  parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cbd_in_if.sink     in_if,
  cbd_out_if.source  out_if,
  cbd_cfg_if.sink    cfg_if
);
  import cbd_pkg::*;

  localparam int RAM_AW = $clog2(RAM_DEPTH);

  function automatic logic [RAM_AW-1:0] ram_index(input logic [ADDR_W-1:0] a);
    logic [11:0] v;
    v = {1'b0, a[10:0]};
    for (int k = 3; k >= 0; k--) begin
      if (int'(v) >= (RAM_DEPTH << k)) begin
        v = v - 12'(RAM_DEPTH << k);
      end
    end
    return RAM_AW'(v);
  endfunction

  logic                clr_active_r;
  logic [RAM_AW-1:0]   clr_addr_r;

  logic [SRATE_W-1:0]  sample_rate_r;
  logic [CRATE_W-1:0]  cpu_clock_rate_r;

  logic [2:0]          phase_r, phase_nxt;
  logic                dma_active_r, dma_active_nxt;
  logic                await_even_r, await_even_nxt;
  logic [7:0]          dma_page_r, dma_page_nxt;
  logic [7:0]          dma_offset_r, dma_offset_nxt;
  logic [DATA_W-1:0]   dma_latch_r, dma_latch_nxt;
  logic                ext_pend_r, ext_pend_nxt;
  logic [DATA_W-1:0]   pad_shift_r, pad_shift_nxt;
  logic [CRATE_W-1:0]  acc_r, acc_nxt;
  logic                latch_load_r;

  logic                s1_valid_r;
  res_t                s1_res_r;
  logic                s1_ram_rd_r;
  logic                out_valid_r;
  res_t                out_res_r;

  logic                in_accept;
  logic                s1_adv;
  res_t                res;
  res_t                s1_final;
  logic                cpu_ram_rd;
  logic                dma_ram_rd;
  logic                cpu_we;
  logic [RAM_AW-1:0]   ram_raddr;
  logic [RAM_AW-1:0]   cpu_waddr;
  logic                ram_we;
  logic [RAM_AW-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;

  logic                even;
  logic                aw;
  logic                wr;
  logic [ADDR_W-1:0]   dma_a;
  logic [ADDR_W-1:0]   a;
  logic [DATA_W-1:0]   latch_cur;
  logic [CRATE_W:0]    acc_sum;

  assign in_accept    = in_if.valid && in_if.ready;
  assign s1_adv       = !out_valid_r || out_if.ready;
  assign in_if.ready  = !clr_active_r && (!s1_valid_r || s1_adv);
  assign cfg_if.ready = 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    dma_active_nxt = dma_active_r;
    await_even_nxt = await_even_r;
    dma_page_nxt   = dma_page_r;
    dma_offset_nxt = dma_offset_r;
    dma_latch_nxt  = dma_latch_r;
    ext_pend_nxt   = ext_pend_r;
    pad_shift_nxt  = pad_shift_r;
    acc_nxt        = acc_r;
    res            = '0;
    cpu_ram_rd     = 1'b0;
    dma_ram_rd     = 1'b0;
    cpu_we         = 1'b0;
    ram_raddr      = '0;
    even           = 1'b0;
    aw             = 1'b0;
    wr             = 1'b0;
    latch_cur      = dma_latch_r;
    acc_sum        = '0;
    a              = in_if.address;
    dma_a          = {dma_page_r, dma_offset_r};
    cpu_waddr      = ram_index(in_if.address);
    if (in_accept) begin
      case (kind_t'(in_if.kind))
        KIND_TICK: begin
          if (ext_pend_r) begin
            latch_cur    = in_if.bus_read_data;
            ext_pend_nxt = 1'b0;
          end
          dma_latch_nxt = latch_cur;
          if (phase_r == PHASE_EVEN || phase_r == PHASE_ODD) begin
            even = (phase_r == PHASE_EVEN);
            if (dma_active_r) begin
              aw             = await_even_r && !even;
              await_even_nxt = aw;
              if (!aw) begin
                if (even) begin
                  if (!in_if.cart_claims && dma_a < RAM_END) begin
                    dma_ram_rd = 1'b1;
                    ram_raddr  = ram_index(dma_a);
                  end else if (!in_if.cart_claims && dma_a == PAD_ADDR) begin
                    dma_latch_nxt = {{(DATA_W-1){1'b0}}, pad_shift_r[DATA_W-1]};
                    pad_shift_nxt = {pad_shift_r[DATA_W-2:0], 1'b0};
                  end else begin
                    res.dma_op      = DMA_RD_REQ;
                    res.dma_address = dma_a;
                    ext_pend_nxt    = 1'b1;
                  end
                end else begin
                  res.dma_op     = DMA_WR_OAM;
                  res.dma_data   = latch_cur;
                  dma_offset_nxt = dma_offset_r + 8'd1;
                  if (dma_offset_r == 8'hFF) begin
                    await_even_nxt = 1'b1;
                    dma_active_nxt = 1'b0;
                  end
                end
              end
            end else begin
              res.cpu_step = 1'b1;
            end
            res.apu_step = 1'b1;
            acc_sum = {1'b0, acc_r} + (CRATE_W+1)'(sample_rate_r);
            if (acc_sum >= (CRATE_W+1)'(cpu_clock_rate_r)) begin
              res.sample_pulse = 1'b1;
              acc_nxt = CRATE_W'(acc_sum - (CRATE_W+1)'(cpu_clock_rate_r));
            end else begin
              acc_nxt = acc_sum[CRATE_W-1:0];
            end
          end
          res.cpu_nmi = in_if.ppu_nmi;
          res.cpu_irq = in_if.apu_irq;
          phase_nxt   = (phase_r == PHASE_LAST) ? 3'd0 : phase_r + 3'd1;
        end
        KIND_WRITE, KIND_READ: begin
          wr = (kind_t'(in_if.kind) == KIND_WRITE);
          if (in_if.cart_claims) begin
            res.target        = TGT_CART;
            res.local_address = a;
          end else if (a < RAM_END) begin
            res.target        = TGT_RAM;
            res.local_address = ADDR_W'(ram_index(a));
            if (wr) begin
              cpu_we = 1'b1;
            end else begin
              cpu_ram_rd = 1'b1;
              ram_raddr  = ram_index(a);
            end
          end else if (a < PPU_END) begin
            res.target        = TGT_PPU;
            res.local_address = {13'd0, a[2:0]};
          end else if ((a >= APU_BASE && a <= APU_LAST) || a == APU_STATUS ||
                       a == APU_FRAME) begin
            res.target        = TGT_APU;
            res.local_address = a;
          end else if (a == PAD_ADDR) begin
            res.target = TGT_PAD;
            if (wr) begin
              pad_shift_nxt = in_if.pad_buttons;
            end else begin
              res.read_data = {{(DATA_W-1){1'b0}}, pad_shift_r[DATA_W-1]};
              pad_shift_nxt = {pad_shift_r[DATA_W-2:0], 1'b0};
            end
          end else if (a == OAM_DMA_ADDR && wr) begin
            res.target     = TGT_DMA;
            dma_page_nxt   = in_if.write_data;
            dma_active_nxt = 1'b1;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  assign ram_we    = clr_active_r || cpu_we;
  assign ram_waddr = clr_active_r ? clr_addr_r : cpu_waddr;
  assign ram_wdata = clr_active_r ? '0 : in_if.write_data;

  cbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_work_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cpu_ram_rd || dma_ram_rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == RAM_AW'(RAM_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r    <= SAMPLE_RATE_RST;
      cpu_clock_rate_r <= CPU_CLOCK_RATE_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_idx_t'(cfg_if.index))
        CFG_SAMPLE_RATE:    sample_rate_r    <= cfg_if.data[SRATE_W-1:0];
        CFG_CPU_CLOCK_RATE: cpu_clock_rate_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      dma_active_r <= 1'b0;
      await_even_r <= 1'b1;
      dma_page_r   <= '0;
      dma_offset_r <= '0;
      dma_latch_r  <= '0;
      ext_pend_r   <= 1'b0;
      pad_shift_r  <= '0;
      acc_r        <= '0;
      latch_load_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      dma_active_r <= dma_active_nxt;
      await_even_r <= await_even_nxt;
      dma_page_r   <= dma_page_nxt;
      dma_offset_r <= dma_offset_nxt;
      ext_pend_r   <= ext_pend_nxt;
      pad_shift_r  <= pad_shift_nxt;
      acc_r        <= acc_nxt;
      latch_load_r <= dma_ram_rd;
      // take the RAM byte in the cycle after the DMA read was issued
      dma_latch_r  <= latch_load_r ? ram_rdata : dma_latch_nxt;
    end
  end

  always_comb begin
    s1_final = s1_res_r;
    if (s1_ram_rd_r) begin
      s1_final.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_valid_r && s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res_r    <= res;
      s1_ram_rd_r <= cpu_ram_rd;
    end
    if (s1_valid_r && s1_adv) begin
      out_res_r <= s1_final;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.target        = out_res_r.target;
  assign out_if.local_address = out_res_r.local_address;
  assign out_if.read_data     = out_res_r.read_data;
  assign out_if.cpu_step      = out_res_r.cpu_step;
  assign out_if.apu_step      = out_res_r.apu_step;
  assign out_if.dma_op        = out_res_r.dma_op;
  assign out_if.dma_address   = out_res_r.dma_address;
  assign out_if.dma_data      = out_res_r.dma_data;
  assign out_if.sample_pulse  = out_res_r.sample_pulse;
  assign out_if.cpu_nmi       = out_res_r.cpu_nmi;
  assign out_if.cpu_irq       = out_res_r.cpu_irq;

endmodule

>>> rtl/core/cbd_checker.sv
// Port-level checker for the bus decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_target
);
  logic [1:0] inflight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 2'((in_valid && in_ready) ? 1 : 0)
                               - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  `CBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_target), "stalled result dropped or changed")
  `CBD_ASSERT_IMPL(a_out_has_item, out_valid, inflight_r != 2'd0, "result without accepted beat")
  `CBD_ASSERT_IMPL(a_inflight_max, in_valid || out_valid, inflight_r <= 2'd2, "more than two beats in flight")
  `CBD_ASSERT_NEXT(a_clear_after_reset, $rose(rst_n), !in_ready, "input taken during RAM clear")

endmodule

bind cpu_bus_decoder_with_oam_dma cbd_checker u_cbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_target (out_if.target)
);

>>> verif/testbench.sv
// Testbench for cpu_bus_decoder_with_oam_dma: bus decode, work RAM, pad shifter, OAM DMA and
// sample pacing, checked beat by beat against an in-bench model of the bus.
// Depends on cbd_pkg, cbd_in_if, cbd_out_if, cbd_cfg_if and the RTL top level.
`timescale 1ns / 100ps

module testbench;
  import cbd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 10000;
  localparam int PHASE_ITEMS = 170;
  localparam int DMA_ITEMS   = 240;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              cart_claims;
    logic [DATA_W-1:0] pad_buttons;
    logic [DATA_W-1:0] bus_read_data;
    logic              ppu_nmi;
    logic              apu_irq;
  } bus_item_t;

  typedef struct packed {
    bus_item_t         item;
    logic              known;
    target_t           tgt;
    logic [ADDR_W-1:0] la;
    logic [DATA_W-1:0] rd;
    logic              steps;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [25] = '{
    '{'{KIND_TICK,   16'h0000, 8'h00, '0, 8'h00, 8'h00, '1, '0}, '1, TGT_NONE, 16'h0000, '0, '1},
    '{'{KIND_TICK,   16'h0000, 8'h00, '0, 8'h00, 8'h00, '0, '1}, '1, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_READ,   16'h0000, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_RAM,  16'h0000, '0, '0},
    '{'{KIND_WRITE,  16'h1FFF, 8'hFF, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_RAM,  16'h07FF, '0, '0},
    '{'{KIND_READ,   16'h07FF, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '0, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_READ,   16'h0800, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '0, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_WRITE,  16'hFFFF, 8'h5A, '1, 8'h00, 8'h00, '0, '0}, '1, TGT_CART, 16'hFFFF, '0, '0},
    '{'{KIND_READ,   16'h0000, 8'h00, '1, 8'h00, 8'h00, '0, '0}, '1, TGT_CART, 16'h0000, '0, '0},
    '{'{KIND_READ,   16'h2000, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_PPU,  16'h0000, '0, '0},
    '{'{KIND_WRITE,  16'h3FFF, 8'h81, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_PPU,  16'h0007, '0, '0},
    '{'{KIND_WRITE,  16'h4000, 8'h3C, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_APU,  16'h4000, '0, '0},
    '{'{KIND_READ,   16'h4013, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_APU,  16'h4013, '0, '0},
    '{'{KIND_READ,   16'h4015, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_APU,  16'h4015, '0, '0},
    '{'{KIND_WRITE,  16'h4017, 8'hC0, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_APU,  16'h4017, '0, '0},
    '{'{KIND_READ,   16'h4014, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_READ,   16'h4018, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_WRITE,  16'hFFFF, 8'h77, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_UNUSED, 16'hFFFF, 8'hFF, '1, 8'hFF, 8'hFF, '1, '1}, '1, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_WRITE,  16'h4016, 8'h00, '0, 8'hA5, 8'h00, '0, '0}, '1, TGT_PAD,  16'h0000, '0, '0},
    '{'{KIND_READ,   16'h4016, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '0, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_READ,   16'h4016, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '0, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_WRITE,  16'h4014, 8'h00, '0, 8'h00, 8'h00, '0, '0}, '1, TGT_DMA,  16'h0000, '0, '0},
    '{'{KIND_TICK,   16'h0000, 8'h00, '0, 8'h00, 8'h5A, '1, '1}, '0, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_TICK,   16'h0000, 8'h00, '1, 8'h00, 8'hA5, '0, '0}, '0, TGT_NONE, 16'h0000, '0, '0},
    '{'{KIND_TICK,   16'h0000, 8'h00, '0, 8'h00, 8'hFF, '1, '0}, '0, TGT_NONE, 16'h0000, '0, '0}
  };

  logic clk;
  logic rst_n;

  cbd_in_if  in_ch ();
  cbd_out_if out_ch ();
  cbd_cfg_if cfg_ch ();

  cpu_bus_decoder_with_oam_dma dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // bus model state
  logic [DATA_W-1:0]  ram_model [RAM_DEPTH_DEF];
  logic [2:0]         tick_ph;
  bit                 dma_on;
  bit                 wait_even;
  logic [7:0]         dma_pg;
  logic [7:0]         dma_off;
  logic [7:0]         dma_byte;
  bit                 ext_pending;
  logic [7:0]         pad_sr;
  logic [31:0]        sample_acc;
  logic [SRATE_W-1:0] srate;
  logic [CRATE_W-1:0] crate;

  res_t expected_beats [$];
  int   errors;
  int   burst_left;
  bit   hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic pad_pop();
    logic b;
    b = pad_sr[7];
    pad_sr = {pad_sr[6:0], 1'b0};
    return b;
  endfunction

  task automatic model_bus(input bus_item_t it, output res_t r);
    logic [ADDR_W-1:0] a;
    logic              even;
    logic              wr;
    r = '0;
    a = it.address;
    wr = (it.kind == KIND_WRITE);
    if (it.kind == KIND_TICK) begin
      if (ext_pending) begin
        dma_byte = it.bus_read_data;
        ext_pending = 0;
      end
      if (tick_ph == PHASE_EVEN || tick_ph == PHASE_ODD) begin
        even = (tick_ph == PHASE_EVEN);
        if (dma_on) begin
          if (wait_even && even) wait_even = 0;
          if (!wait_even) begin
            if (even) begin
              a = {dma_pg, dma_off};
              if (!it.cart_claims && a < RAM_END) begin
                dma_byte = ram_model[a & 16'h07FF];
              end else if (!it.cart_claims && a == PAD_ADDR) begin
                dma_byte = {7'd0, pad_pop()};
              end else begin
                r.dma_op = DMA_RD_REQ;
                r.dma_address = a;
                ext_pending = 1;
              end
            end else begin
              r.dma_op = DMA_WR_OAM;
              r.dma_data = dma_byte;
              dma_off = dma_off + 8'd1;
              if (dma_off == 8'd0) begin
                wait_even = 1;
                dma_on = 0;
              end
            end
          end
        end else begin
          r.cpu_step = 1'b1;
        end
        r.apu_step = 1'b1;
        sample_acc = sample_acc + srate;
        if (sample_acc >= crate) begin
          r.sample_pulse = 1'b1;
          sample_acc = sample_acc - crate;
        end
        sample_acc = sample_acc & 32'h001F_FFFF;
      end
      r.cpu_nmi = it.ppu_nmi;
      r.cpu_irq = it.apu_irq;
      tick_ph = (tick_ph == PHASE_LAST) ? 3'd0 : tick_ph + 3'd1;
    end else if (it.kind == KIND_WRITE || it.kind == KIND_READ) begin
      if (it.cart_claims) begin
        r.target = TGT_CART;
        r.local_address = a;
      end else if (a < RAM_END) begin
        r.target = TGT_RAM;
        r.local_address = a & 16'h07FF;
        if (wr) ram_model[a & 16'h07FF] = it.write_data;
        else r.read_data = ram_model[a & 16'h07FF];
      end else if (a < PPU_END) begin
        r.target = TGT_PPU;
        r.local_address = a & 16'h0007;
      end else if ((a >= APU_BASE && a <= APU_LAST) || a == APU_STATUS || a == APU_FRAME) begin
        r.target = TGT_APU;
        r.local_address = a;
      end else if (a == PAD_ADDR) begin
        r.target = TGT_PAD;
        if (wr) pad_sr = it.pad_buttons;
        else r.read_data = {7'd0, pad_pop()};
      end else if (a == OAM_DMA_ADDR && wr) begin
        r.target = TGT_DMA;
        dma_pg = it.write_data;
        dma_on = 1;
      end
    end
  endtask

  function automatic bus_item_t rand_item(int tick_pct);
    bus_item_t it;
    int        r;
    r = $urandom_range(99);
    if (r < tick_pct) it.kind = KIND_TICK;
    else if (r < tick_pct + 2) it.kind = KIND_UNUSED;
    else it.kind = $urandom_range(1) ? KIND_WRITE : KIND_READ;
    r = $urandom_range(99);
    if (r < 35) it.address = 16'($urandom_range(16'h1FFF));
    else if (r < 45) it.address = 16'($urandom_range(16'h3FFF, 16'h2000));
    else if (r < 80) it.address = 16'($urandom_range(16'h401F, 16'h4000));
    else if (r < 90) it.address = 16'($urandom_range(16'hFFFF, 16'h4020));
    else it.address = 16'($urandom());
    it.write_data = 8'($urandom());
    it.cart_claims = ($urandom_range(99) < 15);
    it.pad_buttons = 8'($urandom());
    it.bus_read_data = 8'($urandom());
    it.ppu_nmi = 1'($urandom_range(1));
    it.apu_irq = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_beat(bus_item_t it, bit typed, res_t typed_res);
    res_t pred;
    int   gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.kind = it.kind;
    in_ch.address = it.address;
    in_ch.write_data = it.write_data;
    in_ch.cart_claims = it.cart_claims;
    in_ch.pad_buttons = it.pad_buttons;
    in_ch.bus_read_data = it.bus_read_data;
    in_ch.ppu_nmi = it.ppu_nmi;
    in_ch.apu_irq = it.apu_irq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model_bus(it, pred);
    expected_beats.push_back(typed ? typed_res : pred);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, ($urandom_range(3) == 0) ? 12 : 2);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CRATE_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_SAMPLE_RATE) srate = v[SRATE_W-1:0];
    else crate = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] e, logic [15:0] a);
    if (a !== e) begin
      $error("%s: expected %0h, actual %0h", name, e, a);
      errors++;
    end
  endtask

  // receiver: rotating stall pattern, plus a long hold-off on request
  initial begin
    int cyc;
    int hold_cnt;
    cyc = 0;
    hold_cnt = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready = 1'b0;
      end else begin
        case ((cyc / 100) % 3)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = (cyc % 4 != 1);
          default: out_ch.ready = 1'($urandom_range(1));
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_beats.pop_front();
        check_field("target", 16'(e.target), 16'(out_ch.target));
        check_field("local_address", e.local_address, out_ch.local_address);
        check_field("read_data", 16'(e.read_data), 16'(out_ch.read_data));
        check_field("cpu_step", 16'(e.cpu_step), 16'(out_ch.cpu_step));
        check_field("apu_step", 16'(e.apu_step), 16'(out_ch.apu_step));
        check_field("dma_op", 16'(e.dma_op), 16'(out_ch.dma_op));
        check_field("dma_address", e.dma_address, out_ch.dma_address);
        check_field("dma_data", 16'(e.dma_data), 16'(out_ch.dma_data));
        check_field("sample_pulse", 16'(e.sample_pulse), 16'(out_ch.sample_pulse));
        check_field("cpu_nmi", 16'(e.cpu_nmi), 16'(out_ch.cpu_nmi));
        check_field("cpu_irq", 16'(e.cpu_irq), 16'(out_ch.cpu_irq));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    res_t typed_res;
    int   n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_TICK;
    in_ch.address = '0;
    in_ch.write_data = '0;
    in_ch.cart_claims = 1'b0;
    in_ch.pad_buttons = '0;
    in_ch.bus_read_data = '0;
    in_ch.ppu_nmi = 1'b0;
    in_ch.apu_irq = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SAMPLE_RATE;
    cfg_ch.data = '0;
    errors = 0;
    burst_left = 8;
    hold_req = 0;
    foreach (ram_model[i]) ram_model[i] = '0;
    tick_ph = '0;
    dma_on = 0;
    wait_even = 1;
    dma_pg = '0;
    dma_off = '0;
    dma_byte = '0;
    ext_pending = 0;
    pad_sr = '0;
    sample_acc = '0;
    srate = SAMPLE_RATE_RST;
    crate = CPU_CLOCK_RATE_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIR_TABLE[i]) begin
      typed_res = '0;
      if (DIR_TABLE[i].known) begin
        typed_res.target = DIR_TABLE[i].tgt;
        typed_res.local_address = DIR_TABLE[i].la;
        typed_res.read_data = DIR_TABLE[i].rd;
        typed_res.cpu_step = DIR_TABLE[i].steps;
        typed_res.apu_step = DIR_TABLE[i].steps;
        if (DIR_TABLE[i].item.kind == KIND_TICK) begin
          typed_res.cpu_nmi = DIR_TABLE[i].item.ppu_nmi;
          typed_res.cpu_irq = DIR_TABLE[i].item.apu_irq;
        end
      end
      send_beat(DIR_TABLE[i].item, DIR_TABLE[i].known, typed_res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          cfg_write(CFG_SAMPLE_RATE, 21'd192000);
          cfg_write(CFG_CPU_CLOCK_RATE, 21'd192001);
        end
        1: begin
          cfg_write(CFG_SAMPLE_RATE, 21'd1);
          cfg_write(CFG_CPU_CLOCK_RATE, 21'd2000000);
          hold_req = 1;
        end
        2: begin
          cfg_write(CFG_SAMPLE_RATE, 21'h1FFFFF);
          cfg_write(CFG_CPU_CLOCK_RATE, 21'h1FFFFF);
        end
        default: begin
          cfg_write(CFG_SAMPLE_RATE, 21'($urandom_range(192000, 1)));
          cfg_write(CFG_CPU_CLOCK_RATE, 21'($urandom_range(2000000, 192001)));
        end
      endcase
      repeat (PHASE_ITEMS) send_beat(rand_item(50), 1'b0, '0);
    end

    // start a DMA on the pad page, then restart it into a work RAM page
    settle();
    cfg_write(CFG_SAMPLE_RATE, CRATE_W'(SAMPLE_RATE_RST));
    cfg_write(CFG_CPU_CLOCK_RATE, CPU_CLOCK_RATE_RST);
    send_beat(bus_item_t'{KIND_WRITE, PAD_ADDR, 8'h00, 1'b0, 8'($urandom()), 8'h00, 1'b0, 1'b0},
              1'b0, '0);
    send_beat(bus_item_t'{KIND_WRITE, OAM_DMA_ADDR, 8'h40, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
              1'b0, '0);
    for (n = 0; n < DMA_ITEMS; n++) begin
      if (n == DMA_ITEMS / 2) begin
        send_beat(bus_item_t'{KIND_WRITE, OAM_DMA_ADDR, 8'h07, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
                  1'b0, '0);
      end else begin
        send_beat(rand_item(85), 1'b0, '0);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
